FILE: rtl/efp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efp_pkg: shared definitions for the escape-time fractal pixel core
// Fixed-point formats, iteration limits, datapath commands and status.
// ----------------------------------------------------------------------------
package efp_pkg;

  // Iteration and format settings
  localparam int MAX_ITER   = 512;
  localparam int INDEX_BITS = 10;
  localparam int FRAC_BITS  = 28;

  // Port widths
  localparam int IDX_PORT_W = 10;
  localparam int ITER_W     = 10;
  localparam int COLOR_W    = 3;
  localparam int STEP_W     = 31;
  localparam int JC_W       = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Index bits that take part in the mapping
  localparam int IDX_KEEP = (INDEX_BITS < IDX_PORT_W) ? INDEX_BITS : IDX_PORT_W;

  // Datapath widths
  localparam int WORD_W  = 32;
  localparam int PROD_W  = 2 * WORD_W;
  localparam int SQ_W    = 2 * WORD_W - FRAC_BITS;      // floor(z*z) for any 32-bit z
  localparam int CROSS_W = 2 * WORD_W - FRAC_BITS + 1;  // floor(2*zr*zi)
  localparam int SUM_W   = SQ_W + 2;
  localparam int MAG_W   = SQ_W + 1;
  localparam int CNT_W   = $clog2(MAX_ITER + 1);

  // Color digit positions
  localparam int RED_SHIFT   = 6;
  localparam int GREEN_SHIFT = 3;

  // Fixed-point constants
  localparam logic signed [PROD_W-1:0] TWO_P   = PROD_W'(64'sd2 <<< FRAC_BITS);
  localparam logic signed [MAG_W-1:0]  LIMIT_M = MAG_W'(64'sd4 <<< FRAC_BITS);
  localparam logic signed [PROD_W-1:0] WORD_MAX_P =
    PROD_W'((64'sd1 <<< (WORD_W - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] WORD_MIN_P = PROD_W'(-(64'sd1 <<< (WORD_W - 1)));

  // Default Julia constant -0.8 + 0.156i, given at 28 fractional bits
  localparam int signed DEF_CR_Q28 = -214748365;
  localparam int signed DEF_CI_Q28 = 41875931;
  localparam logic signed [WORD_W-1:0] DEF_CR = WORD_W'(DEF_CR_Q28 >>> (28 - FRAC_BITS));
  localparam logic signed [WORD_W-1:0] DEF_CI = WORD_W'(DEF_CI_Q28 >>> (28 - FRAC_BITS));

  // Register reset values
  localparam logic [STEP_W-1:0]      ROW_STEP_RST = STEP_W'(4194304);
  localparam logic [STEP_W-1:0]      COL_STEP_RST = STEP_W'(4194304);
  localparam logic signed [JC_W-1:0] JC_REAL_RST  = JC_W'(-214748365);
  localparam logic signed [JC_W-1:0] JC_IMAG_RST  = JC_W'(41875931);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JC_REAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JC_IMAG  = 3'd4;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_MAP_ROW = 3'd2,
    OP_MAP_COL = 3'd3,
    OP_SQ_R    = 3'd4,
    OP_SQ_I    = 3'd5,
    OP_CROSS   = 3'd6,
    OP_UPDATE  = 3'd7
  } op_e;

  typedef struct packed {
    op_e  op;
    logic store;   // capture the finished count into the result register
  } cmd_t;

  typedef struct packed {
    logic escape;  // |z|^2 of the current z exceeds 4.0
    logic at_max;  // iteration limit reached
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/efp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efp_datapath: fixed-point datapath of the fractal pixel core
// Configuration registers, point mapping and z = z*z + c through one shared
// 32x32 signed multiplier, iteration counter and result register.
// ----------------------------------------------------------------------------
module efp_datapath import efp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [IDX_PORT_W-1:0] row_index_i,
  input  wire logic [IDX_PORT_W-1:0] col_index_i,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  output logic [ITER_W-1:0]          iterations_o,
  output logic [COLOR_W-1:0]         red_o,
  output logic [COLOR_W-1:0]         green_o,
  output logic [COLOR_W-1:0]         blue_o
);

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] x);
    logic signed [WORD_W-1:0] r;
    if (x > WORD_MAX_P) begin
      r = WORD_W'(WORD_MAX_P);
    end else if (x < WORD_MIN_P) begin
      r = WORD_W'(WORD_MIN_P);
    end else begin
      r = WORD_W'(x);
    end
    return r;
  endfunction

  // Configuration registers
  logic                     mode_q;
  logic [STEP_W-1:0]        row_step_q;
  logic [STEP_W-1:0]        col_step_q;
  logic signed [JC_W-1:0]   jc_real_q;
  logic signed [JC_W-1:0]   jc_imag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      row_step_q <= ROW_STEP_RST;
      col_step_q <= COL_STEP_RST;
      jc_real_q  <= JC_REAL_RST;
      jc_imag_q  <= JC_IMAG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:     mode_q     <= cfg_wdata_i[0];
        CFG_ROW_STEP: row_step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_COL_STEP: col_step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_JC_REAL:  jc_real_q  <= cfg_wdata_i[JC_W-1:0];
        CFG_JC_IMAG:  jc_imag_q  <= cfg_wdata_i[JC_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers
  logic [IDX_KEEP-1:0]       row_q, col_q;
  logic signed [WORD_W-1:0]  zr_q, zi_q, cr_q, ci_q;
  logic signed [SQ_W-1:0]    rr_q, ii_q;
  logic signed [CROSS_W-1:0] ri_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [CNT_W-1:0]          res_q;

  // Julia constant, with the default when both parts are zero
  logic                     jc_zero;
  logic signed [WORD_W-1:0] jcr, jci;
  assign jc_zero = (jc_real_q == '0) && (jc_imag_q == '0);
  assign jcr     = jc_zero ? DEF_CR : WORD_W'(jc_real_q);
  assign jci     = jc_zero ? DEF_CI : WORD_W'(jc_imag_q);

  // Shared multiplier with operand selection
  logic signed [WORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    unique case (cmd_i.op)
      OP_MAP_ROW: begin
        mul_a = signed'({{(WORD_W-IDX_KEEP){1'b0}}, row_q});
        mul_b = signed'({1'b0, row_step_q});
      end
      OP_MAP_COL: begin
        mul_a = signed'({{(WORD_W-IDX_KEEP){1'b0}}, col_q});
        mul_b = signed'({1'b0, col_step_q});
      end
      OP_SQ_I: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      OP_CROSS: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  logic signed [WORD_W-1:0]  point;
  logic signed [PROD_W-1:0]  prod_sq, prod_cross;
  logic signed [SUM_W-1:0]   sum_r, sum_i;
  assign point      = sat_word(prod - TWO_P);
  assign prod_sq    = prod >>> FRAC_BITS;
  assign prod_cross = prod >>> (FRAC_BITS - 1);
  assign sum_r      = SUM_W'(rr_q) - SUM_W'(ii_q) + SUM_W'(cr_q);
  assign sum_i      = SUM_W'(ri_q) + SUM_W'(ci_q);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        row_q <= row_index_i[IDX_KEEP-1:0];
        col_q <= col_index_i[IDX_KEEP-1:0];
        cnt_q <= '0;
        if (mode_q) begin
          cr_q <= jcr;
          ci_q <= jci;
        end else begin
          zr_q <= '0;
          zi_q <= '0;
        end
      end
      OP_MAP_ROW: begin
        if (mode_q) begin
          zi_q <= point;
        end else begin
          cr_q <= point;
        end
      end
      OP_MAP_COL: begin
        if (mode_q) begin
          zr_q <= point;
        end else begin
          ci_q <= point;
        end
      end
      OP_SQ_R:  rr_q <= SQ_W'(prod_sq);
      OP_SQ_I:  ii_q <= SQ_W'(prod_sq);
      OP_CROSS: ri_q <= CROSS_W'(prod_cross);
      OP_UPDATE: begin
        zr_q  <= sat_word(PROD_W'(sum_r));
        zi_q  <= sat_word(PROD_W'(sum_i));
        cnt_q <= cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
    if (cmd_i.store) begin
      res_q <= cnt_q;
    end
  end

  // Escape test on the squares of the current z; the start point is never tested
  logic signed [MAG_W-1:0] mag;
  assign mag             = MAG_W'(rr_q) + MAG_W'(ii_q);
  assign status_o.escape = (cnt_q != '0) && (mag > LIMIT_M);
  assign status_o.at_max = (cnt_q == CNT_W'(MAX_ITER));

  assign iterations_o = ITER_W'(res_q);
  assign red_o        = COLOR_W'(res_q >> RED_SHIFT);
  assign green_o      = COLOR_W'(res_q >> GREEN_SHIFT);
  assign blue_o       = COLOR_W'(res_q);

endmodule
`default_nettype wire

FILE: rtl/efp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efp_ctrl: sequencer of the fractal pixel core
// Steps the datapath through mapping and the multiply passes of each
// iteration, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module efp_ctrl import efp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_MAP_ROW = 8'b0000_0010,
    S_MAP_COL = 8'b0000_0100,
    S_SQ_R    = 8'b0000_1000,
    S_SQ_I    = 8'b0001_0000,
    S_CROSS   = 8'b0010_0000,
    S_UPDATE  = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   done;

  assign done = status_i.escape || status_i.at_max;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = OP_NONE;
    cmd_o.store = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_MAP_ROW;
        end
      end
      S_MAP_ROW: begin
        cmd_o.op = OP_MAP_ROW;
        state_d  = S_MAP_COL;
      end
      S_MAP_COL: begin
        cmd_o.op = OP_MAP_COL;
        state_d  = S_SQ_R;
      end
      S_SQ_R: begin
        cmd_o.op = OP_SQ_R;
        state_d  = S_SQ_I;
      end
      S_SQ_I: begin
        cmd_o.op = OP_SQ_I;
        state_d  = S_CROSS;
      end
      S_CROSS: begin
        cmd_o.op = OP_CROSS;
        state_d  = done ? S_FINISH : S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = S_SQ_R;
      end
      S_FINISH: begin
        // hold until the result slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.store = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_store_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> (!out_valid_q || out_ready_i))
    else $error("result stored over an untaken result");

  a_accept_starts_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MAP_ROW))
    else $error("accepted transfer did not start mapping");

  a_iter_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CROSS && !done) |=> (state_q == S_UPDATE) ##1 (state_q == S_SQ_R))
    else $error("iteration loop broken");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("result valid raised outside finish");
`endif

endmodule
`default_nettype wire

FILE: rtl/escape_time_fractal_pixel_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core: Mandelbrot / Julia escape-time pixel engine
// Maps a pixel's row and column to a Q4.28 point and counts iterations of
// z = z*z + c until |z|^2 > 4 or the iteration limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries row_index_i and
//   col_index_i; one pixel is worked on at a time. Output channel
//   (out_valid_o / out_ready_i) returns iterations_o and the 3-bit color
//   digits red_o, green_o, blue_o, one result per pixel.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   once and must be made by the user while no pixel is in flight; the
//   block itself does not enforce this. out_valid_o and in_ready_o rise
//   in the same cycle once a pixel is done. The time a pixel takes grows
//   with the returned count N (1 to 512) and is set by the single shared
//   32x32 multiplier: three products per iteration (zr^2, zi^2, zr*zi)
//   plus one update step, and two mapping products.
//   A finished result sits in an output register, so the next pixel is
//   taken and iterated while the receiver stalls; only storing its result
//   waits for the register to empty.
//   Reset clears the controller and the output valid, and loads the
//   configuration registers with their defaults (Mandelbrot, step 1/64).
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_core import efp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [IDX_PORT_W-1:0] row_index_i,
  input  wire logic [IDX_PORT_W-1:0] col_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [ITER_W-1:0]          iterations_o,
  output logic [COLOR_W-1:0]         red_o,
  output logic [COLOR_W-1:0]         green_o,
  output logic [COLOR_W-1:0]         blue_o
);

  cmd_t    cmd;
  status_t status;

  efp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  efp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .iterations_o (iterations_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

endmodule
`default_nettype wire
